// ===== hw/rtl/ssde_pkg.sv =====
// Shared constants and types for the sorted-stream distinct estimator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ssde_pkg;

  // Default sample row limit and fixed field widths.
  localparam int unsigned MAX_ROWS_DEF = 65536;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned NT_W         = 40;
  localparam int unsigned CNT_OUT_W    = 17;

  // Length of the current run of equal keys.
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_ONE  = 2'd1,
    RUN_MANY = 2'd2
  } run_len_t;

  // Estimator sequencer states, one-hot.
  typedef enum logic [4:0] {
    EST_IDLE   = 5'b00001,
    EST_PROD   = 5'b00010,
    EST_SCALE  = 5'b00100,
    EST_DIVIDE = 5'b01000,
    EST_LOAD   = 5'b10000
  } est_state_t;

endpackage

// ===== hw/rtl/ssde_stats.sv =====
// Sample statistics: counts rows, distinct keys and singleton keys of a sorted stream.
// Depends on ssde_pkg.
`timescale 1ns / 1ps

module ssde_stats
  import ssde_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [KEY_W-1:0] key,
  input  logic             last,
  output logic             snap_valid,
  output logic [CNT_W-1:0] snap_n,
  output logic [CNT_W-1:0] snap_d,
  output logic [CNT_W-1:0] snap_f1,
  output logic             snap_sat
);

  localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);

  logic [KEY_W-1:0] prev_key, prev_key_next;
  logic             have_prev, have_prev_next;
  run_len_t         run_len, run_len_next;
  logic [CNT_W-1:0] distinct_count, distinct_count_next;
  logic [CNT_W-1:0] single_count, single_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic             saturated, saturated_next;

  // Effect of one row on the counters. A row past the limit is dropped.
  always_comb begin
    prev_key_next       = prev_key;
    have_prev_next      = have_prev;
    run_len_next        = run_len;
    distinct_count_next = distinct_count;
    single_count_next   = single_count;
    row_count_next      = row_count;
    saturated_next      = saturated;
    if (row_count == ROW_LIMIT) begin
      saturated_next = 1'b1;
    end else begin
      row_count_next = row_count + 1'b1;
      if (!have_prev || key != prev_key) begin
        if (have_prev && run_len == RUN_ONE) begin
          single_count_next = single_count + 1'b1;
        end
        distinct_count_next = distinct_count + 1'b1;
        run_len_next        = RUN_ONE;
        prev_key_next       = key;
        have_prev_next      = 1'b1;
      end else if (run_len == RUN_ONE) begin
        run_len_next = RUN_MANY;
      end
    end
  end

  // The final row hands its updated counts to the estimator; an open run of one counts.
  assign snap_valid = accept && last;
  assign snap_n     = row_count_next;
  assign snap_d     = distinct_count_next;
  assign snap_f1    = single_count_next + CNT_W'(run_len_next == RUN_ONE);
  assign snap_sat   = saturated_next;

  // Control state; a finished sample starts over from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev      <= 1'b0;
      run_len        <= RUN_NONE;
      distinct_count <= '0;
      single_count   <= '0;
      row_count      <= '0;
      saturated      <= 1'b0;
    end else if (accept) begin
      if (last) begin
        have_prev      <= 1'b0;
        run_len        <= RUN_NONE;
        distinct_count <= '0;
        single_count   <= '0;
        row_count      <= '0;
        saturated      <= 1'b0;
      end else begin
        have_prev      <= have_prev_next;
        run_len        <= run_len_next;
        distinct_count <= distinct_count_next;
        single_count   <= single_count_next;
        row_count      <= row_count_next;
        saturated      <= saturated_next;
      end
    end
  end

  // The stored key is only read while have_prev is set.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_key <= prev_key_next;
    end
  end

endmodule

// ===== hw/rtl/ssde_ser_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on ssde_pkg for default widths.
`timescale 1ns / 1ps

module ssde_ser_mul
  import ssde_pkg::*;
#(
  parameter int unsigned A_W = NT_W,
  parameter int unsigned B_W = NT_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int unsigned CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_reg;
  logic [B_W-1:0] b_reg;
  logic [CW-1:0]  bits_left;
  logic           busy;
  logic [A_W:0]   partial;

  // Add the multiplicand into the upper half when the current multiplier bit is set.
  assign partial = {1'b0, prod[A_W+B_W-1:B_W]} + (b_reg[0] ? {1'b0, a_reg} : '0);

  // Bit counter and a one-cycle done pulse once the last bit has been applied.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        bits_left <= CW'(B_W);
      end else if (busy) begin
        bits_left <= bits_left - 1'b1;
        if (bits_left == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Product accumulates from the top and shifts right one place per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
    end else if (busy) begin
      prod  <= {partial, prod[B_W-1:1]};
      b_reg <= b_reg >> 1;
    end
  end

endmodule

// ===== hw/rtl/ssde_ser_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle, MSB of the dividend first.
// Depends on ssde_pkg for default widths.
`timescale 1ns / 1ps

module ssde_ser_div
  import ssde_pkg::*;
#(
  parameter int unsigned NUM_W = 2 * NT_W,
  parameter int unsigned DEN_W = NT_W,
  parameter int unsigned Q_W   = NT_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo,
  output logic [DEN_W-1:0] rem
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_reg;
  logic [DEN_W-1:0] den_reg;
  logic [CW-1:0]    bits_left;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem, num_reg[NUM_W-1]};
  assign diff  = trial - {1'b0, den_reg};
  assign fits  = trial >= {1'b0, den_reg};

  // Bit counter and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        bits_left <= CW'(NUM_W);
      end else if (busy) begin
        bits_left <= bits_left - 1'b1;
        if (bits_left == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder stays below the divisor, so the kept bits never lose information.
  always_ff @(posedge clk) begin
    if (start) begin
      num_reg <= num;
      den_reg <= den;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num_reg <= num_reg << 1;
      rem     <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo     <= {quo[Q_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/ssde_est.sv =====
// Estimate sequencer: serial products, serial division, rounding, clamping, output register.
// Depends on ssde_pkg, ssde_ser_mul and ssde_ser_div.
`timescale 1ns / 1ps

module ssde_est
  import ssde_pkg::*;
#(
  parameter int unsigned CNT_W = $clog2(MAX_ROWS_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CNT_W-1:0]     n,
  input  logic [CNT_W-1:0]     d,
  input  logic [CNT_W-1:0]     f1,
  input  logic                 sat,
  input  logic [NT_W-1:0]      total_rows,
  output logic                 idle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NT_W-1:0]      estimate,
  output logic [CNT_OUT_W-1:0] distinct_seen,
  output logic [CNT_OUT_W-1:0] singletons,
  output logic                 overflow
);

  localparam int unsigned ND_W  = 2 * CNT_W;
  localparam int unsigned NUM_W = ND_W + NT_W;
  localparam int unsigned DEN_W = CNT_W + NT_W;
  localparam int unsigned Q_W   = ((CNT_W > NT_W) ? CNT_W : NT_W) + 1;

  est_state_t state;

  logic [CNT_W-1:0] n_reg, d_reg, f1_reg;
  logic             sat_reg;
  logic [NT_W-1:0]  nt_reg;
  logic [DEN_W-1:0] den_reg;
  logic [Q_W-1:0]   q_reg;

  logic             go;
  logic             nd_done, fn_done, num_done, dm_done, div_done;
  logic [ND_W-1:0]  nd_prod, fn_prod;
  logic [NUM_W-1:0] num_prod;
  logic [DEN_W-1:0] dm_prod;
  logic [DEN_W-1:0] den_sum;
  logic [Q_W-1:0]   quo;
  logic [DEN_W-1:0] rem;
  logic             round_up;
  logic             scale_go, div_go;
  logic [Q_W-1:0]   q_base, q_low, q_final;
  logic             load;

  assign idle     = (state == EST_IDLE);
  assign go       = idle && start;
  assign scale_go = (state == EST_PROD) && nd_done && fn_done;
  assign div_go   = (state == EST_SCALE) && num_done && dm_done;

  // First pass: n*d and f1*n, both stepping through the bits of n.
  ssde_ser_mul #(.A_W(CNT_W), .B_W(CNT_W)) u_nd (
    .clk(clk), .rst(rst), .start(go), .a(d), .b(n), .done(nd_done), .prod(nd_prod)
  );

  ssde_ser_mul #(.A_W(CNT_W), .B_W(CNT_W)) u_fn (
    .clk(clk), .rst(rst), .start(go), .a(f1), .b(n), .done(fn_done), .prod(fn_prod)
  );

  // Second pass: scale n*d and (n - f1) by the table size.
  ssde_ser_mul #(.A_W(ND_W), .B_W(NT_W)) u_num (
    .clk(clk), .rst(rst), .start(scale_go), .a(nd_prod), .b(nt_reg),
    .done(num_done), .prod(num_prod)
  );

  ssde_ser_mul #(.A_W(CNT_W), .B_W(NT_W)) u_dm (
    .clk(clk), .rst(rst), .start(scale_go), .a(n_reg - f1_reg), .b(nt_reg),
    .done(dm_done), .prod(dm_prod)
  );

  // Denominator (n - f1)*N + f1*n always fits in DEN_W bits.
  assign den_sum = dm_prod + DEN_W'(fn_prod);

  ssde_ser_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(num_prod), .den(den_sum),
    .done(div_done), .quo(quo), .rem(rem)
  );

  // Round half up: add one when twice the remainder reaches the divisor.
  assign round_up = ({rem, 1'b0} >= {1'b0, den_reg});

  // An empty sample has no ratio; it falls through the clamps to min(d, N).
  assign q_base  = (n_reg == '0) ? '0 : q_reg;
  assign q_low   = (q_base < Q_W'(d_reg)) ? Q_W'(d_reg) : q_base;
  assign q_final = (q_low > Q_W'(nt_reg)) ? Q_W'(nt_reg) : q_low;
  assign load    = (state == EST_LOAD) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EST_IDLE;
    end else begin
      case (state)
        EST_IDLE: begin
          if (start) begin
            state <= EST_PROD;
          end
        end
        EST_PROD: begin
          if (scale_go) begin
            state <= EST_SCALE;
          end
        end
        EST_SCALE: begin
          if (div_go) begin
            state <= EST_DIVIDE;
          end
        end
        EST_DIVIDE: begin
          if (div_done) begin
            state <= EST_LOAD;
          end
        end
        EST_LOAD: begin
          if (load) begin
            state <= EST_IDLE;
          end
        end
        default: begin
          state <= EST_IDLE;
        end
      endcase
    end
  end

  // Operands of the sample in flight; a table size of zero counts as one.
  always_ff @(posedge clk) begin
    if (go) begin
      n_reg   <= n;
      d_reg   <= d;
      f1_reg  <= f1;
      sat_reg <= sat;
      nt_reg  <= (total_rows == '0) ? NT_W'(1) : total_rows;
    end
    if (div_go) begin
      den_reg <= den_sum;
    end
    if (state == EST_DIVIDE && div_done) begin
      q_reg <= quo + Q_W'(round_up);
    end
  end

  // Output register; the sequencer waits in EST_LOAD while it is full and not being read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      estimate      <= q_final[NT_W-1:0];
      distinct_seen <= CNT_OUT_W'(d_reg);
      singletons    <= CNT_OUT_W'(f1_reg);
      overflow      <= sat_reg;
    end
  end

endmodule

// ===== hw/rtl/sorted_stream_distinct_estimator_core.sv =====
// Top level of the sorted-stream distinct estimator (Duj1).
// Depends on ssde_pkg, ssde_stats and ssde_est.
`timescale 1ns / 1ps

// Usage:
// Sorted sample keys enter on the in_valid/in_ready channel, one transaction per
// row, with last marking the final row. Rows before the last are taken one per
// cycle. A sample produces one out_valid/out_ready transaction with the rounded,
// clamped Duj1 estimate, the distinct and singleton counts, and the overflow flag.
// The estimate is formed by bit-serial multipliers and a restoring divider
// whose dividend is NUM_W = 2 * CNT_W + 40 bits wide, where CNT_W =
// clog2(MAX_ROWS + 1); the dividend width sets most of the time from the
// last row's transaction to out_valid.
// Rows of the next sample keep streaming during that time; its last row is
// held off (in_ready low) until the estimator is free again.
// A result that the receiver stalls stays in the output register, and the
// estimator waits behind it.
// cfg_we writes total_rows (zero acts as one) and should only be used while
// idle. Reset clears all counts and sets total_rows to one.

module sorted_stream_distinct_estimator_core
  import ssde_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_W-1:0]     key,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NT_W-1:0]      estimate,
  output logic [CNT_OUT_W-1:0] distinct_seen,
  output logic [CNT_OUT_W-1:0] singletons,
  output logic                 overflow,
  input  logic                 cfg_we,
  input  logic [NT_W-1:0]      cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);

  logic [NT_W-1:0]  total_rows;
  logic             accept;
  logic             est_idle;
  logic             snap_valid;
  logic [CNT_W-1:0] snap_n, snap_d, snap_f1;
  logic             snap_sat;

  // Table size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_rows <= NT_W'(1);
    end else if (cfg_we) begin
      total_rows <= cfg_wdata;
    end
  end

  // Ordinary rows always pass; a final row waits for a free estimator.
  assign in_ready = est_idle || !last;
  assign accept   = in_valid && in_ready;

  ssde_stats #(.MAX_ROWS(MAX_ROWS)) u_stats (
    .clk(clk), .rst(rst), .accept(accept), .key(key), .last(last),
    .snap_valid(snap_valid), .snap_n(snap_n), .snap_d(snap_d),
    .snap_f1(snap_f1), .snap_sat(snap_sat)
  );

  ssde_est #(.CNT_W(CNT_W)) u_est (
    .clk(clk), .rst(rst), .start(snap_valid), .n(snap_n), .d(snap_d),
    .f1(snap_f1), .sat(snap_sat), .total_rows(total_rows), .idle(est_idle),
    .out_valid(out_valid), .out_ready(out_ready), .estimate(estimate),
    .distinct_seen(distinct_seen), .singletons(singletons), .overflow(overflow)
  );

  // A finished sample is only handed over when the estimator can take it.
  a_handoff_free: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> est_idle)
    else $error("sample handed to a busy estimator");

  // Counts are consistent: singletons within distinct keys within rows, rows nonzero.
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> (snap_f1 <= snap_d) && (snap_d <= snap_n) && (snap_n != '0))
    else $error("inconsistent sample counts");

  // Saturation only happens with the row counter at its limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap_sat |-> snap_n == CNT_W'(MAX_ROWS))
    else $error("overflow flagged below the row limit");

endmodule

// ===== tb/sv/sorted_stream_distinct_estimator_core_tb.sv =====
// Self-checking testbench for sorted_stream_distinct_estimator_core.
// Streams sorted and unsorted samples, predicts each Duj1 result and compares it.
// Depends on ssde_pkg and the core RTL only.
`timescale 1ns / 1ps

module sorted_stream_distinct_estimator_core_tb
  import ssde_pkg::*;
();

  localparam int unsigned ROW_LIMIT     = MAX_ROWS_DEF;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam logic [NT_W-1:0] NT_MAX    = {NT_W{1'b1}};

  // One sample row as offered on the input channel.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } sample_row_t;

  // One estimator result as seen on the output channel.
  typedef struct packed {
    logic [NT_W-1:0]      estimate;
    logic [CNT_OUT_W-1:0] distinct_seen;
    logic [CNT_OUT_W-1:0] singletons;
    logic                 overflow;
  } est_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KEY_W-1:0]     key = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [NT_W-1:0]      estimate;
  logic [CNT_OUT_W-1:0] distinct_seen;
  logic [CNT_OUT_W-1:0] singletons;
  logic                 overflow;
  logic                 cfg_we = 1'b0;
  logic [NT_W-1:0]      cfg_wdata = '0;

  sample_row_t pending_rows[$];
  est_result_t pending_estimates[$];
  int unsigned rows_queued  = 0;
  int unsigned rows_offered = 0;
  int unsigned rows_taken   = 0;
  int unsigned errors       = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Predicted state of the block.
  logic [KEY_W-1:0] prev_key;
  bit               have_prev;
  run_len_t         run;
  int unsigned      distinct_cnt;
  int unsigned      single_cnt;
  int unsigned      row_cnt;
  bit               sat;
  logic [NT_W-1:0]  table_rows;

  sorted_stream_distinct_estimator_core #(
    .MAX_ROWS(ROW_LIMIT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .key           (key),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .estimate      (estimate),
    .distinct_seen (distinct_seen),
    .singletons    (singletons),
    .overflow      (overflow),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Rounded, clamped Duj1 estimate computed with exact integer arithmetic.
  function automatic logic [NT_W-1:0] duj1_estimate(input logic [63:0] n, input logic [63:0] d,
                                                     input logic [63:0] f1, input logic [63:0] nt);
    logic [63:0]  den;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  q;
    den = (n - f1) * nt + f1 * n;
    if (den == 0) return (d < nt) ? d[NT_W-1:0] : nt[NT_W-1:0];
    num = 128'(n * d) * 128'(nt);
    quo = num / 128'(den);
    rem = num % 128'(den);
    q = quo[63:0];
    // Round half up: bump when twice the remainder reaches the divisor.
    if (rem >= 128'(den) - rem) q = q + 1;
    if (q < d) q = d;
    if (q > nt) q = nt;
    return q[NT_W-1:0];
  endfunction

  task automatic clear_sample();
    prev_key     = '0;
    have_prev    = 1'b0;
    run          = RUN_NONE;
    distinct_cnt = 0;
    single_cnt   = 0;
    row_cnt      = 0;
    sat          = 1'b0;
  endtask

  // Update the run and count state for one accepted row; a final row queues the predicted result.
  task automatic count_row(input logic [KEY_W-1:0] k, input logic is_last);
    logic [63:0] nt;
    logic [63:0] f1;
    est_result_t r;
    if (row_cnt >= ROW_LIMIT) begin
      // The row is dropped, only the flag records it.
      sat = 1'b1;
    end else begin
      row_cnt++;
      if (!have_prev || k != prev_key) begin
        if (have_prev && run == RUN_ONE) single_cnt++;
        distinct_cnt++;
        run       = RUN_ONE;
        prev_key  = k;
        have_prev = 1'b1;
      end else if (run == RUN_ONE) begin
        run = RUN_MANY;
      end
    end
    if (is_last) begin
      nt = (table_rows == 0) ? 64'd1 : 64'(table_rows);
      f1 = 64'(single_cnt) + ((run == RUN_ONE) ? 64'd1 : 64'd0);
      r.estimate      = duj1_estimate(64'(row_cnt), 64'(distinct_cnt), f1, nt);
      r.distinct_seen = distinct_cnt[CNT_OUT_W-1:0];
      r.singletons    = f1[CNT_OUT_W-1:0];
      r.overflow      = sat;
      pending_estimates.push_back(r);
      clear_sample();
    end
  endtask

  // Sample both channels and the config port, predict and check.
  always @(posedge clk) begin
    est_result_t want;
    if (rst) begin
      clear_sample();
      table_rows = NT_W'(1);
    end else begin
      if (cfg_we) table_rows = cfg_wdata;
      if (in_valid && in_ready) begin
        rows_taken++;
        count_row(key, last);
      end
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected transaction, estimate %0d distinct %0d singletons %0d",
                   $time, estimate, distinct_seen, singletons);
          errors++;
        end else begin
          want = pending_estimates.pop_front();
          if (estimate !== want.estimate) begin
            $display("%0t: estimate expected %0d actual %0d", $time, want.estimate, estimate);
            errors++;
          end
          if (distinct_seen !== want.distinct_seen) begin
            $display("%0t: distinct_seen expected %0d actual %0d",
                     $time, want.distinct_seen, distinct_seen);
            errors++;
          end
          if (singletons !== want.singletons) begin
            $display("%0t: singletons expected %0d actual %0d",
                     $time, want.singletons, singletons);
            errors++;
          end
          if (overflow !== want.overflow) begin
            $display("%0t: overflow expected %0d actual %0d", $time, want.overflow, overflow);
            errors++;
          end
        end
      end
    end
  end

  // Row driver: offers the next queued row once the current transaction is done.
  always @(negedge clk) begin
    sample_row_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || rows_taken == rows_offered) begin
      if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_rows.pop_front();
        in_valid     <= 1'b1;
        key          <= r.key;
        last         <= r.last;
        rows_offered <= rows_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus long requested hold-offs.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_row(input logic [KEY_W-1:0] k, input logic is_last);
    sample_row_t r;
    r.key  = k;
    r.last = is_last;
    pending_rows.push_back(r);
    rows_queued++;
  endtask

  // One sample with random content; sorted runs or shuffled keys.
  task automatic queue_sample(input int unsigned len, input bit shuffled);
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    for (int unsigned i = 0; i < len; i++) begin
      if (i != 0) begin
        if (shuffled) begin
          if ($urandom_range(3) != 0) k = {$urandom, $urandom};
        end else begin
          case ($urandom_range(3))
            // Half the time the key repeats and extends the run.
            0, 1: k = k;
            2: k = k + 1;
            default: k = k + 64'($urandom_range(2, 65535));
          endcase
        end
      end
      queue_row(k, i == len - 1);
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned start;
    start = rows_queued;
    while (rows_queued - start < count) begin
      if ($urandom_range(9) == 0) queue_sample($urandom_range(13, 40), 1'b0);
      else queue_sample($urandom_range(1, 12), $urandom_range(99) < 15);
    end
  endtask

  // Wait until every row is taken and every result is back, then let the divider settle.
  task automatic drain();
    while (rows_taken != rows_queued || pending_estimates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_table_rows(input logic [NT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst           <= 1'b0;
    send_idle_pct <= 34;
    recv_idle_pct <= 64;
    @(posedge clk);

    // Reset value of total_rows, extreme keys.
    queue_row('0, 1'b1);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);

    // Zero total_rows behaves as one.
    set_table_rows('0);
    queue_row(64'd10, 1'b0);
    queue_row(64'd20, 1'b0);
    queue_row(64'd30, 1'b1);

    // Largest table: long runs, mixed runs, unsorted keys, single rows.
    set_table_rows(NT_MAX);
    queue_row(64'd5, 1'b0);
    queue_row(64'd5, 1'b0);
    queue_row(64'd5, 1'b1);
    queue_row(64'd1, 1'b0);
    queue_row(64'd2, 1'b0);
    queue_row(64'd2, 1'b0);
    queue_row(64'd3, 1'b1);
    queue_row(64'd9, 1'b0);
    queue_row(64'd3, 1'b0);
    queue_row(64'd9, 1'b1);
    queue_row(64'h8000_0000_0000_0000, 1'b1);
    queue_row(64'd7, 1'b0);
    queue_row(64'd7, 1'b0);
    queue_row(64'd8, 1'b1);

    // Random samples while the receiver holds off long enough to back up the input.
    set_table_rows(NT_W'({$urandom, $urandom}));
    queue_random(70);
    @(negedge clk);
    hold_req <= hold_req + 1;
    set_table_rows(40'($urandom_range(1, 64)));
    queue_random(60);

    // Swap the idle rates; the sender pauses until all results are in midway.
    drain();
    send_idle_pct <= 64;
    recv_idle_pct <= 34;
    set_table_rows(40'($urandom_range(2, 100000)));
    queue_random(60);
    drain();
    @(posedge clk);
    queue_random(60);
    set_table_rows(NT_W'({$urandom, $urandom}));
    queue_random(40);

    // No idling: a table smaller than the sample, then random samples.
    drain();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_table_rows(40'd3);
    queue_random(40);
    set_table_rows(NT_W'({$urandom, $urandom}));
    queue_random(60);
    set_table_rows(NT_MAX);
    // A short run of one key on its own.
    queue_row(64'd4, 1'b0);
    queue_row(64'd4, 1'b1);

    drain();
    if (errors == 0) begin
      $display("sorted_stream_distinct_estimator_core verification clean");
    end else begin
      $display("sorted_stream_distinct_estimator_core verification failed");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #8_000_000;
    $display("sorted_stream_distinct_estimator_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ssde_pkg.sv
hw/rtl/ssde_stats.sv
hw/rtl/ssde_ser_mul.sv
hw/rtl/ssde_ser_div.sv
hw/rtl/ssde_est.sv
hw/rtl/sorted_stream_distinct_estimator_core.sv
tb/sv/sorted_stream_distinct_estimator_core_tb.sv
